[hdl/mlfd_pkg.sv]
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the marker/length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] END_MARK   = 8'h21;

  // start, type, source and length bytes, plus the end marker
  localparam int HEADER_LEN     = 4;
  localparam int FRAME_OVERHEAD = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ID    = 2'd2
  } kind_t;

  // received byte with its marker flags worked out up front
  typedef struct packed {
    logic       is_end;
    logic       is_start;
    logic [7:0] data;
  } rx_word_t;

  typedef struct packed {
    logic     valid;
    rx_word_t word;
  } rx_queue_t;

  function automatic rx_word_t classify(input logic [7:0] b);
    rx_word_t w;
    w.data     = b;
    w.is_start = (b == START_MARK);
    w.is_end   = (b == END_MARK);
    return w;
  endfunction

endpackage

[hdl/marker_length_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// marker_length_frame_deframer_core
// Deframer for '~' type source length payload '!' frames on a byte link.
//
//   port group  direction  handshake          payload
//   in_         word in    in_valid/in_stall  in_rx_byte
//   out_        word out   out_valid/out_stall kind, type, source, data, index, last
//   cfg_        write      cfg_wr_en          cfg_wr_data (info frame type)
//
// A byte is appended to the buffer and, once four are buffered, the
// header is read through the single buffer read port; a bad start byte,
// an oversized length or a bad end marker drops one byte and rescans,
// and a good frame goes out as result words.
// Reset is synchronous; the buffer needs no clearing pass. A four-word queue
// keeps taking bytes while a stalled result holds the scanner.
// ----------------------------------------------------------------------------
module marker_length_frame_deframer_core #(
  parameter int BUF_DEPTH   = 64,
  parameter int MAX_PAYLOAD = 59
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_msg_type,
  output logic [7:0] out_source,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0]          info_type_r;
  mlfd_pkg::rx_queue_t q_word;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      info_type_r <= 8'd0;
    end else if (cfg_wr_en) begin
      info_type_r <= cfg_wr_data;
    end
  end

  mlfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_out      (q_word),
    .q_pop      (q_pop)
  );

  mlfd_back #(
    .BUF_DEPTH   (BUF_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_in            (q_word),
    .q_pop           (q_pop),
    .info_frame_type (info_type_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_msg_type    (out_msg_type),
    .out_source      (out_source),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last)
  );

endmodule

[hdl/mlfd_ram.sv]
// ----------------------------------------------------------------------------
// mlfd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/mlfd_front.sv]
// ----------------------------------------------------------------------------
// mlfd_front
// Input side: takes received bytes, tags start and end markers and queues
// them for the frame scanner.
// ----------------------------------------------------------------------------
module mlfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output mlfd_pkg::rx_queue_t q_out,
  input  logic                q_pop
);

  mlfd_pkg::rx_word_t               mem_r [mlfd_pkg::QUEUE_DEPTH];
  logic [mlfd_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [mlfd_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [mlfd_pkg::QCNT_W-1:0]      cnt_r;
  logic                             push;

  assign in_stall   = (cnt_r == mlfd_pkg::QCNT_W'(mlfd_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign q_out.valid = (cnt_r != '0);
  assign q_out.word  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= mlfd_pkg::classify(in_rx_byte);
    end
  end

endmodule

[hdl/mlfd_back.sv]
// ----------------------------------------------------------------------------
// mlfd_back
// Frame scanner: appends queued words to a circular receive buffer, walks
// the buffer for frames and drives the result register.
// ----------------------------------------------------------------------------
module mlfd_back #(
  parameter int BUF_DEPTH   = 64,
  parameter int MAX_PAYLOAD = 59
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mlfd_pkg::rx_queue_t q_in,
  output logic                q_pop,
  input  logic [7:0]          info_frame_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_msg_type,
  output logic [7:0]          out_source,
  output logic [7:0]          out_data_byte,
  output logic [5:0]          out_byte_index,
  output logic                out_last
);

  localparam int PTR_W   = $clog2(BUF_DEPTH);
  localparam int CNT_W   = $clog2(BUF_DEPTH + 1);
  localparam int LIMIT_I = (MAX_PAYLOAD < BUF_DEPTH - mlfd_pkg::FRAME_OVERHEAD) ?
                           MAX_PAYLOAD : BUF_DEPTH - mlfd_pkg::FRAME_OVERHEAD;
  localparam logic [8:0]       LIMIT   = 9'(LIMIT_I);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);
  localparam int WORD_W = $bits(mlfd_pkg::rx_word_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_H1,
    S_H2,
    S_H3,
    S_H4,
    S_END_RD,
    S_END_CHK,
    S_EMIT,
    S_PAYLOAD
  } state_t;

  function automatic logic [PTR_W-1:0] add_mod(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(BUF_DEPTH)) begin
      s = s - (CNT_W+1)'(BUF_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  state_t              state_r,  state_nxt;
  logic [PTR_W-1:0]    head_r,   head_nxt;
  logic [CNT_W-1:0]    count_r,  count_nxt;
  logic [7:0]          typ_r,    typ_nxt;
  logic [7:0]          src_r,    src_nxt;
  logic [7:0]          len_r,    len_nxt;
  logic [CNT_W-1:0]    flen_r,   flen_nxt;
  logic [7:0]          idx_r,    idx_nxt;
  logic [PTR_W-1:0]    pl_ptr_r, pl_ptr_nxt;
  mlfd_pkg::kind_t     kind_r,   kind_nxt;
  logic [7:0]          rx_id_r,  rx_id_nxt;

  logic                out_valid_r, out_valid_nxt;
  mlfd_pkg::kind_t     out_kind_r,  out_kind_nxt;
  logic [7:0]          out_type_r,  out_type_nxt;
  logic [7:0]          out_src_r,   out_src_nxt;
  logic [7:0]          out_data_r,  out_data_nxt;
  logic [5:0]          out_idx_r,   out_idx_nxt;
  logic                out_last_r,  out_last_nxt;

  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [WORD_W-1:0]   rd_raw;
  mlfd_pkg::rx_word_t  rd_word;

  logic                slot_free;
  logic                out_load;
  logic [CNT_W-1:0]    flen_c;
  logic                pl_last;

  mlfd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (q_in.word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_word   = mlfd_pkg::rx_word_t'(rd_raw);
  assign slot_free = !out_valid_r || !out_stall;
  // only meaningful once the length has passed the limit check
  assign flen_c    = CNT_W'(rd_word.data) + CNT_W'(mlfd_pkg::FRAME_OVERHEAD);
  assign pl_last   = ((idx_r + 8'd1) == len_r);
  assign wr_addr   = add_mod(head_r, count_r);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    typ_nxt      = typ_r;
    src_nxt      = src_r;
    len_nxt      = len_r;
    flen_nxt     = flen_r;
    idx_nxt      = idx_r;
    pl_ptr_nxt   = pl_ptr_r;
    kind_nxt     = kind_r;
    rx_id_nxt    = rx_id_r;
    out_kind_nxt = out_kind_r;
    out_type_nxt = out_type_r;
    out_src_nxt  = out_src_r;
    out_data_nxt = out_data_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;
    out_load     = 1'b0;
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          q_pop = 1'b1;
          // a word arriving on a full buffer is dropped
          if (count_r != DEPTH_C) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (count_r < CNT_W'(mlfd_pkg::HEADER_LEN)) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = S_H1;
        end
      end
      S_H1: begin
        if (!rd_word.is_start) begin
          head_nxt  = add_mod(head_r, CNT_W'(1));
          count_nxt = count_r - 1'b1;
          state_nxt = S_SCAN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = add_mod(head_r, CNT_W'(1));
          state_nxt = S_H2;
        end
      end
      S_H2: begin
        typ_nxt   = rd_word.data;
        rd_en     = 1'b1;
        rd_addr   = add_mod(head_r, CNT_W'(2));
        state_nxt = S_H3;
      end
      S_H3: begin
        src_nxt   = rd_word.data;
        rd_en     = 1'b1;
        rd_addr   = add_mod(head_r, CNT_W'(3));
        state_nxt = S_H4;
      end
      S_H4: begin
        priority if ({1'b0, rd_word.data} > LIMIT) begin
          // oversized length counts as a bad start byte
          head_nxt  = add_mod(head_r, CNT_W'(1));
          count_nxt = count_r - 1'b1;
          state_nxt = S_SCAN;
        end else if (count_r < flen_c) begin
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = rd_word.data;
          flen_nxt  = flen_c;
          state_nxt = S_END_RD;
        end
      end
      S_END_RD: begin
        rd_en     = 1'b1;
        rd_addr   = add_mod(head_r, flen_r - 1'b1);
        state_nxt = S_END_CHK;
      end
      S_END_CHK: begin
        priority if (!rd_word.is_end) begin
          head_nxt  = add_mod(head_r, CNT_W'(1));
          count_nxt = count_r - 1'b1;
          state_nxt = S_SCAN;
        end else if (typ_r == info_frame_type) begin
          rx_id_nxt = src_r;
          kind_nxt  = mlfd_pkg::KIND_ID;
          state_nxt = S_EMIT;
        end else if (len_r == 8'd0) begin
          kind_nxt  = mlfd_pkg::KIND_EMPTY;
          state_nxt = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = add_mod(head_r, CNT_W'(mlfd_pkg::HEADER_LEN));
          pl_ptr_nxt = add_mod(head_r, CNT_W'(mlfd_pkg::HEADER_LEN + 1));
          idx_nxt    = 8'd0;
          state_nxt  = S_PAYLOAD;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_kind_nxt = kind_r;
          out_type_nxt = typ_r;
          out_src_nxt  = (kind_r == mlfd_pkg::KIND_ID) ? rx_id_r : src_r;
          out_data_nxt = 8'd0;
          out_idx_nxt  = 6'd0;
          out_last_nxt = 1'b1;
          head_nxt     = add_mod(head_r, flen_r);
          count_nxt    = count_r - flen_r;
          state_nxt    = S_SCAN;
        end
      end
      S_PAYLOAD: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_kind_nxt = mlfd_pkg::KIND_DATA;
          out_type_nxt = typ_r;
          out_src_nxt  = src_r;
          out_data_nxt = rd_word.data;
          out_idx_nxt  = idx_r[5:0];
          out_last_nxt = pl_last;
          if (pl_last) begin
            head_nxt  = add_mod(head_r, flen_r);
            count_nxt = count_r - flen_r;
            state_nxt = S_SCAN;
          end else begin
            // fetch the next payload word while this one goes out
            rd_en      = 1'b1;
            rd_addr    = pl_ptr_r;
            pl_ptr_nxt = add_mod(pl_ptr_r, CNT_W'(1));
            idx_nxt    = idx_r + 8'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rx_id_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rx_id_r     <= rx_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    typ_r      <= typ_nxt;
    src_r      <= src_nxt;
    len_r      <= len_nxt;
    flen_r     <= flen_nxt;
    idx_r      <= idx_nxt;
    pl_ptr_r   <= pl_ptr_nxt;
    kind_r     <= kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_type_r <= out_type_nxt;
    out_src_r  <= out_src_nxt;
    out_data_r <= out_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_msg_type   = out_type_r;
  assign out_source     = out_src_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("buffer fill above depth");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && q_in.valid)
    else $error("queue popped outside idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_pl_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAYLOAD) |-> (len_r != 8'd0) && (idx_r < len_r))
    else $error("payload index past frame length");

  a_frame_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_PAYLOAD) |-> (flen_r <= count_r))
    else $error("frame longer than buffered data");

endmodule
